/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/rsr_pkg.sv */
// ----------------------------------------------------------------------------
// rsr_pkg
// Types and constants of the reliable stream receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rsr_pkg;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_NACK   = 2'd1;
    localparam logic [1:0] KIND_FINACK = 2'd2;

    localparam logic [7:0] PKT_DATA = 8'd0;
    localparam logic [7:0] PKT_FIN  = 8'd3;

    localparam logic [7:0] WIRE_ACK    = 8'd1;
    localparam logic [7:0] WIRE_NACK   = 8'd2;
    localparam logic [7:0] WIRE_FINACK = 8'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DRAIN,
        ST_CHECK,
        ST_DIV,
        ST_NACK,
        ST_DUP,
        ST_CUM,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        MODE_INORDER,
        MODE_AHEAD,
        MODE_DUP
    } t_mode;

    // Ones-complement checksum over the reply's sequence, window and flag words.
    function automatic logic [15:0] reply_sum(input logic [1:0] kind,
                                              input logic [31:0] seq,
                                              input logic [15:0] win);
        logic [7:0]  flag;
        logic [17:0] s;
        logic [16:0] s1;
        logic [16:0] s2;
        case (kind)
            KIND_ACK:  flag = WIRE_ACK;
            KIND_NACK: flag = WIRE_NACK;
            default:   flag = WIRE_FINACK;
        endcase
        s  = {2'b00, seq[31:16]} + {2'b00, seq[15:0]} + {2'b00, win}
           + {2'b00, flag, 8'h00};
        s1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
        return ~s2[15:0];
    endfunction

endpackage

`default_nettype wire

/* design/reliable_stream_receiver_ack_nack.sv */
// ----------------------------------------------------------------------------
// reliable_stream_receiver_ack_nack
// Selective-repeat receiver header path producing ACK, NACK and FIN-ACK words.
// ----------------------------------------------------------------------------
// One header word is taken at a time; the block is not ready again until all
// replies of that header are loaded into the output register. An ignored
// header passes through the accept and decode states only. A data header then
// passes, for in-order data, a drain step per retired reorder entry plus one
// for the clear entry that ends the run, a check step that starts the
// cumulative-ACK test, a restoring divider for expected modulo window (one bit
// per cycle, skipped when either is zero), and one reply word per cycle while
// the master side accepts. Replies wait in a single output register, so a
// stalled master side holds the sequencer.
`default_nettype none

module reliable_stream_receiver_ack_nack #(
    parameter int REORDER_DEPTH = 64,
    parameter int MAX_NACKS     = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // seq_number[31:0], window[47:32]
    input  wire logic [15:0] s_axis_tuser,  // packet_kind[7:0], checksum_ok[8], zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // reply_seq[31:0], reply_window[47:32],
                                       // reply_checksum[63:48]
    output logic [7:0]  m_axis_tuser,  // reply_kind[1:0], zero
    output logic        m_axis_tlast
);

    localparam int IW = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
    localparam int NW = $clog2(MAX_NACKS + 1);
    localparam logic [31:0] DEPTH32 = 32'(REORDER_DEPTH);
    localparam logic [31:0] NACK32  = 32'(MAX_NACKS);

    rsr_pkg::t_state r_state, n_state;
    rsr_pkg::t_mode  r_mode,  n_mode;

    logic [31:0] r_seq, n_seq;
    logic [15:0] r_win, n_win;
    logic [7:0]  r_kind, n_kind;
    logic        r_ok, n_ok;
    logic [31:0] r_exp, n_exp;
    logic [REORDER_DEPTH-1:0] r_map, n_map;
    logic        r_fin, n_fin;
    logic        r_cum, n_cum;
    logic [31:0] r_dvd, n_dvd;
    logic [15:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic [NW-1:0] r_left, n_left;
    logic [31:0] r_nseq, n_nseq;

    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_okind, n_okind;
    logic [31:0] r_oseq, n_oseq;
    logic [15:0] r_owin, n_owin;
    logic [15:0] r_osum, n_osum;
    logic        r_olast, n_olast;

    logic        free;
    logic [31:0] seq_gap;
    logic [31:0] seq_gap_m1;
    logic [16:0] trial;
    logic [31:0] exp_m1;

    assign free       = !r_ovalid || m_axis_tready;
    assign seq_gap    = r_seq - r_exp;
    assign seq_gap_m1 = seq_gap - 32'd1;
    assign trial      = {r_rem, r_dvd[31]};
    assign exp_m1     = r_exp - 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rsr_pkg::ST_IDLE;
            r_exp    <= '0;
            r_map    <= '0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_exp    <= n_exp;
            r_map    <= n_map;
            r_fin    <= n_fin;
            r_ovalid <= n_ovalid;
        end
        r_mode  <= n_mode;
        r_seq   <= n_seq;
        r_win   <= n_win;
        r_kind  <= n_kind;
        r_ok    <= n_ok;
        r_cum   <= n_cum;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_left  <= n_left;
        r_nseq  <= n_nseq;
        r_okind <= n_okind;
        r_oseq  <= n_oseq;
        r_owin  <= n_owin;
        r_osum  <= n_osum;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_seq    = r_seq;
        n_win    = r_win;
        n_kind   = r_kind;
        n_ok     = r_ok;
        n_exp    = r_exp;
        n_map    = r_map;
        n_fin    = r_fin;
        n_cum    = r_cum;
        n_dvd    = r_dvd;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_nseq   = r_nseq;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_okind  = r_okind;
        n_oseq   = r_oseq;
        n_owin   = r_owin;
        n_osum   = r_osum;
        n_olast  = r_olast;
        s_axis_tready = 1'b0;

        case (r_state)
            rsr_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_seq   = s_axis_tdata[31:0];
                    n_win   = s_axis_tdata[47:32];
                    n_kind  = s_axis_tuser[7:0];
                    n_ok    = s_axis_tuser[8];
                    n_state = rsr_pkg::ST_DECODE;
                end
            end
            rsr_pkg::ST_DECODE: begin
                n_state = rsr_pkg::ST_IDLE;
                if (!r_fin && r_ok) begin
                    if (r_kind == rsr_pkg::PKT_FIN) begin
                        n_state = rsr_pkg::ST_FIN;
                    end else if (r_kind == rsr_pkg::PKT_DATA) begin
                        if (r_seq == r_exp) begin
                            n_mode  = rsr_pkg::MODE_INORDER;
                            n_exp   = r_exp + 32'd1;
                            n_state = rsr_pkg::ST_DRAIN;
                        end else if (r_seq > r_exp) begin
                            n_mode = rsr_pkg::MODE_AHEAD;
                            if (seq_gap <= DEPTH32) begin
                                n_map[seq_gap_m1[IW-1:0]] = 1'b1;
                            end
                            n_left  = (seq_gap < NACK32) ? seq_gap[NW-1:0] : NACK32[NW-1:0];
                            n_nseq  = r_exp;
                            n_state = rsr_pkg::ST_CHECK;
                        end else begin
                            n_mode  = rsr_pkg::MODE_DUP;
                            n_state = rsr_pkg::ST_CHECK;
                        end
                    end
                end
            end
            rsr_pkg::ST_DRAIN: begin
                // Each step retires the head entry; a clear head ends the run.
                n_map = r_map >> 1;
                if (r_map[0]) begin
                    n_exp = r_exp + 32'd1;
                end else begin
                    n_state = rsr_pkg::ST_CHECK;
                end
            end
            rsr_pkg::ST_CHECK: begin
                n_cum = 1'b0;
                n_dvd = r_exp;
                n_rem = '0;
                n_cnt = '0;
                if (r_win != 16'd0 && r_exp != 32'd0) begin
                    n_state = rsr_pkg::ST_DIV;
                end else if (r_mode == rsr_pkg::MODE_AHEAD) begin
                    n_state = rsr_pkg::ST_NACK;
                end else if (r_mode == rsr_pkg::MODE_DUP) begin
                    n_state = rsr_pkg::ST_DUP;
                end else begin
                    n_state = rsr_pkg::ST_IDLE;
                end
            end
            rsr_pkg::ST_DIV: begin
                n_dvd = {r_dvd[30:0], 1'b0};
                if (trial >= {1'b0, r_win}) begin
                    n_rem = 16'(trial - {1'b0, r_win});
                end else begin
                    n_rem = trial[15:0];
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    // The extra step only reads out the final remainder.
                    n_dvd = r_dvd;
                    n_rem = r_rem;
                    n_cum = (r_rem == 16'd0);
                    case (r_mode)
                        rsr_pkg::MODE_AHEAD: n_state = rsr_pkg::ST_NACK;
                        rsr_pkg::MODE_DUP:   n_state = rsr_pkg::ST_DUP;
                        default:             n_state = rsr_pkg::ST_CUM;
                    endcase
                    if (r_mode == rsr_pkg::MODE_INORDER && r_rem != 16'd0) begin
                        n_state = rsr_pkg::ST_IDLE;
                    end
                end
            end
            rsr_pkg::ST_NACK: begin
                if (free) begin
                    n_ovalid = 1'b1;
                    n_okind  = rsr_pkg::KIND_NACK;
                    n_oseq   = r_nseq;
                    n_owin   = r_win;
                    n_osum   = rsr_pkg::reply_sum(rsr_pkg::KIND_NACK, r_nseq, r_win);
                    n_olast  = (r_left == NW'(1)) && !r_cum;
                    n_nseq   = r_nseq + 32'd1;
                    n_left   = r_left - NW'(1);
                    if (r_left == NW'(1)) begin
                        n_state = r_cum ? rsr_pkg::ST_CUM : rsr_pkg::ST_IDLE;
                    end
                end
            end
            rsr_pkg::ST_DUP, rsr_pkg::ST_CUM: begin
                if (free) begin
                    n_ovalid = 1'b1;
                    n_okind  = rsr_pkg::KIND_ACK;
                    n_oseq   = exp_m1;
                    n_owin   = r_win;
                    n_osum   = rsr_pkg::reply_sum(rsr_pkg::KIND_ACK, exp_m1, r_win);
                    n_olast  = (r_state == rsr_pkg::ST_CUM) || !r_cum;
                    n_state  = (r_state == rsr_pkg::ST_DUP && r_cum) ?
                               rsr_pkg::ST_CUM : rsr_pkg::ST_IDLE;
                end
            end
            rsr_pkg::ST_FIN: begin
                if (free) begin
                    n_ovalid = 1'b1;
                    n_okind  = rsr_pkg::KIND_FINACK;
                    n_oseq   = r_seq;
                    n_owin   = r_win;
                    n_osum   = rsr_pkg::reply_sum(rsr_pkg::KIND_FINACK, r_seq, r_win);
                    n_olast  = 1'b1;
                    n_fin    = 1'b1;
                    n_state  = rsr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rsr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_osum, r_owin, r_oseq};
    assign m_axis_tuser  = {6'd0, r_okind};
    assign m_axis_tlast  = r_olast;

endmodule

`default_nettype wire

/* design/rsr_checker.sv */
// ----------------------------------------------------------------------------
// rsr_checker
// Port-level checks of the reliable stream receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rsr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [7:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    logic        stall;
    logic        finack_out;
    logic [72:0] out_word;
    assign stall      = m_axis_tvalid && !m_axis_tready;
    assign finack_out = m_axis_tvalid && (m_axis_tuser[1:0] == rsr_pkg::KIND_FINACK);
    assign out_word   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    `ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, stall, m_axis_tvalid)
    `ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, stall, $stable(out_word))
    `ASSERT_IMPLY(a_kind_legal, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser[1:0] <= rsr_pkg::KIND_FINACK)
    `ASSERT_IMPLY(a_finack_last, i_clk, i_rst_n, finack_out, m_axis_tlast)

endmodule

bind reliable_stream_receiver_ack_nack rsr_checker u_rsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
